// ----- design/trigger_effect_payload_decoder_defines.svh -----
// Assertion macros shared by the trigger-effect payload decoder RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef TRIGGER_EFFECT_PAYLOAD_DECODER_DEFINES_SVH
`define TRIGGER_EFFECT_PAYLOAD_DECODER_DEFINES_SVH

// Checked on every rising clock edge outside reset.
`define TEPD_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define TEPD_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- design/tepd_pkg.sv -----
// Shared types and constants of the trigger-effect payload decoder.
// Depends on nothing; used by the lane, merge and top-level modules.
`default_nettype none

package tepd_pkg;

   // Number of zones, one lane per zone.
   localparam int ZONES = 10;

   // Effect type codes.
   localparam logic [7:0] TYPE_OFF       = 8'h05;
   localparam logic [7:0] TYPE_FEEDBACK  = 8'h21;
   localparam logic [7:0] TYPE_WEAPON    = 8'h25;
   localparam logic [7:0] TYPE_VIBRATION = 8'h26;

   // The only payload length that is well formed.
   localparam logic [7:0] PAYLOAD_LEN = 8'd10;

   // Decoded effect kinds.
   localparam logic [2:0] KIND_NONE        = 3'd0;
   localparam logic [2:0] KIND_FEEDBACK    = 3'd1;
   localparam logic [2:0] KIND_VIBRATION   = 3'd2;
   localparam logic [2:0] KIND_WEAPON      = 3'd3;
   localparam logic [2:0] KIND_MALFORMED   = 3'd4;
   localparam logic [2:0] KIND_UNSUPPORTED = 3'd5;

   // Weapon zone limits.
   localparam logic [3:0] WEAPON_START_MIN = 4'd2;
   localparam logic [3:0] WEAPON_START_MAX = 4'd7;
   localparam logic [3:0] WEAPON_END_MAX   = 4'd8;

   // Ten payload bytes, byte 0 in the low position.
   typedef logic [ZONES-1:0][7:0] octets_type;

   // What one zone lane reports.
   typedef struct packed {
      logic       stray;   // level code set on a zone outside the mask
      logic [3:0] level;   // level in eighths, zero outside the mask
   } lane_type;

   typedef lane_type [ZONES-1:0] lane_vec_type;

   // One decoded result.
   typedef struct packed {
      logic        accepted;
      logic [2:0]  effect_kind;
      logic [39:0] zone_levels;
      logic [7:0]  vibration_frequency;
      logic [3:0]  start_zone;
      logic [3:0]  end_zone;
      logic [3:0]  weapon_strength;
   } result_type;

endpackage

`default_nettype wire

// ----- design/tepd_lane.sv -----
// One zone lane: turns a mask bit and a 3-bit level code into a level in eighths.
// Depends on tepd_pkg for the lane report type.
`default_nettype none

module tepd_lane (
   input  wire logic              mask_bit,
   input  wire logic [2:0]        code,
   output tepd_pkg::lane_type     report
);
   import tepd_pkg::*;

   // A masked zone carries code plus one; an unmasked zone must have a zero code.
   always_comb begin
      report.level = mask_bit ? ({1'b0, code} + 4'd1) : 4'd0;
      report.stray = !mask_bit && (code != 3'd0);
   end

endmodule

`default_nettype wire

// ----- design/tepd_merge.sv -----
// Merging stage: combines the zone lane reports with the type, length and
// reserved-byte checks into one decoded result. Depends on tepd_pkg.
`default_nettype none

module tepd_merge (
   input  wire logic [7:0]            effect_type,
   input  wire logic [7:0]            octet_count,
   input  wire tepd_pkg::octets_type  octets,
   input  wire tepd_pkg::lane_vec_type lanes,
   output tepd_pkg::result_type       result
);
   import tepd_pkg::*;

   logic             mask_hi_zero;
   logic             packed_hi_zero;
   logic [ZONES-1:0] mask_lo;
   logic             stray_any;
   logic [39:0]      levels;
   logic             zone_ok;
   logic             is_vib;
   logic [3:0]       start_idx;
   logic [3:0]       end_idx;
   logic             found;
   logic             weapon_ok;

   // Field checks shared by the zone-carrying types.
   assign mask_hi_zero   = (octets[1][7:2] == 6'd0);
   assign packed_hi_zero = (octets[5][7:6] == 2'd0);
   assign mask_lo        = {octets[1][1:0], octets[0]};
   assign is_vib         = (effect_type == TYPE_VIBRATION);

   // Gather the lane reports.
   always_comb begin
      stray_any = 1'b0;
      levels    = '0;
      for (int i = 0; i < ZONES; i++) begin
         stray_any         = stray_any | lanes[i].stray;
         levels[4*i +: 4]  = lanes[i].level;
      end
   end

   // Feedback and vibration: reserved bytes clear, octet 8 clear for feedback.
   assign zone_ok = mask_hi_zero && packed_hi_zero && !stray_any &&
                    (octets[6] == 8'd0) && (octets[7] == 8'd0) &&
                    (octets[9] == 8'd0) && (is_vib || (octets[8] == 8'd0));

   // Weapon positions: lowest and highest set mask bits.
   always_comb begin
      start_idx = 4'd0;
      end_idx   = 4'd0;
      found     = 1'b0;
      for (int i = 0; i < ZONES; i++) begin
         if (mask_lo[i]) begin
            if (!found) begin
               start_idx = 4'(i);
            end
            found   = 1'b1;
            end_idx = 4'(i);
         end
      end
   end

   assign weapon_ok = mask_hi_zero && (octets[2][7:3] == 5'd0) &&
                      (octets[3] == 8'd0) && (octets[4] == 8'd0) &&
                      (octets[5] == 8'd0) && (octets[6] == 8'd0) &&
                      (octets[7] == 8'd0) && (octets[8] == 8'd0) &&
                      (octets[9] == 8'd0) && ($countones(mask_lo) == 2) &&
                      (start_idx >= WEAPON_START_MIN) &&
                      (start_idx <= WEAPON_START_MAX) &&
                      (end_idx > start_idx) && (end_idx <= WEAPON_END_MAX);

   // Final decision; every field without meaning for the kind stays zero.
   always_comb begin
      result             = '0;
      result.effect_kind = KIND_MALFORMED;
      if (octet_count == PAYLOAD_LEN) begin
         case (effect_type)
            TYPE_OFF: begin
               if (octets == '0) begin
                  result.accepted    = 1'b1;
                  result.effect_kind = KIND_NONE;
               end
            end
            TYPE_FEEDBACK, TYPE_VIBRATION: begin
               if (zone_ok) begin
                  result.accepted = 1'b1;
                  if ((mask_lo == '0) || (is_vib && (octets[8] == 8'd0))) begin
                     result.effect_kind = KIND_NONE;
                  end else begin
                     result.effect_kind         = is_vib ? KIND_VIBRATION : KIND_FEEDBACK;
                     result.zone_levels         = levels;
                     result.vibration_frequency = is_vib ? octets[8] : 8'd0;
                  end
               end
            end
            TYPE_WEAPON: begin
               if (weapon_ok) begin
                  result.accepted        = 1'b1;
                  result.effect_kind     = KIND_WEAPON;
                  result.start_zone      = start_idx;
                  result.end_zone        = end_idx;
                  result.weapon_strength = {1'b0, octets[2][2:0]} + 4'd1;
               end
            end
            default: begin
               result.effect_kind = KIND_UNSUPPORTED;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ----- design/trigger_effect_payload_decoder.sv -----
// Trigger-effect payload decoder: accepts one request transfer per clock cycle
// while req_stall is low and delivers its decoded result from the output register.
// Ten zone lanes decode the levels side by side and a merging stage applies the type
// checks, all combinationally; a two-entry output buffer (output register plus skid
// register) catches a transfer taken while the output is stalled, and req_stall comes
// straight from a register, so there is no combinational path from rsp_stall.
// Depends on tepd_pkg, tepd_lane, tepd_merge and the assertion macro header.
`default_nettype none
`include "trigger_effect_payload_decoder_defines.svh"

module trigger_effect_payload_decoder (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_effect_type,
   input  wire logic [7:0]  req_octet_count,
   input  wire logic [7:0]  req_octet_0,
   input  wire logic [7:0]  req_octet_1,
   input  wire logic [7:0]  req_octet_2,
   input  wire logic [7:0]  req_octet_3,
   input  wire logic [7:0]  req_octet_4,
   input  wire logic [7:0]  req_octet_5,
   input  wire logic [7:0]  req_octet_6,
   input  wire logic [7:0]  req_octet_7,
   input  wire logic [7:0]  req_octet_8,
   input  wire logic [7:0]  req_octet_9,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_accepted,
   output logic [2:0]       rsp_effect_kind,
   output logic [39:0]      rsp_zone_levels,
   output logic [7:0]       rsp_vibration_frequency,
   output logic [3:0]       rsp_start_zone,
   output logic [3:0]       rsp_end_zone,
   output logic [3:0]       rsp_weapon_strength
);
   import tepd_pkg::*;

   octets_type   octets;
   logic [31:0]  packed_levels;
   lane_vec_type lanes;
   result_type   decoded;

   logic         out_valid_ff, out_valid_in;
   result_type   out_data_ff, out_data_in;
   logic         skid_valid_ff, skid_valid_in;
   result_type   skid_data_ff, skid_data_in;
   logic         req_take;
   logic         out_free;

   assign octets = {req_octet_9, req_octet_8, req_octet_7, req_octet_6, req_octet_5,
                    req_octet_4, req_octet_3, req_octet_2, req_octet_1, req_octet_0};

   // Packed level word: bytes 2 to 5, little endian.
   assign packed_levels = {octets[5], octets[4], octets[3], octets[2]};

   // One lane per zone; zone i takes mask bit i and packed level bits 3i..3i+2.
   for (genvar z = 0; z < ZONES; z++) begin : g_lane
      tepd_lane u_lane (
         .mask_bit (octets[z / 8][z % 8]),
         .code     (packed_levels[3*z +: 3]),
         .report   (lanes[z])
      );
   end

   // Merge the lane reports with the type and reserved-byte checks.
   tepd_merge u_merge (
      .effect_type    (req_effect_type),
      .octet_count    (req_octet_count),
      .octets         (octets),
      .lanes          (lanes),
      .result         (decoded)
   );

   // Output buffer: the skid register catches a transfer taken while the
   // output register is held by a stall.
   assign req_stall = skid_valid_ff;
   assign req_take  = req_valid && !skid_valid_ff;
   assign out_free  = !out_valid_ff || !rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = req_take;
            out_data_in  = decoded;
         end
      end else if (req_take) begin
         skid_valid_in = 1'b1;
         skid_data_in  = decoded;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid               = out_valid_ff;
   assign rsp_accepted            = out_data_ff.accepted;
   assign rsp_effect_kind         = out_data_ff.effect_kind;
   assign rsp_zone_levels         = out_data_ff.zone_levels;
   assign rsp_vibration_frequency = out_data_ff.vibration_frequency;
   assign rsp_start_zone          = out_data_ff.start_zone;
   assign rsp_end_zone            = out_data_ff.end_zone;
   assign rsp_weapon_strength     = out_data_ff.weapon_strength;

   // Checks on the decode and the output buffer.
   `TEPD_ASSERT_ALWAYS(a_reset_empties,
      reset |=> !out_valid_ff && !skid_valid_ff,
      "buffer not empty after reset")
   `TEPD_ASSERT(a_skid_behind_out,
      skid_valid_ff |-> out_valid_ff,
      "skid register holds a transfer ahead of the output")
   `TEPD_ASSERT(a_accept_kind,
      (rsp_valid && rsp_accepted) |-> (rsp_effect_kind <= KIND_WEAPON),
      "accepted result carries a rejection kind")
   `TEPD_ASSERT(a_reject_clean,
      (rsp_valid && !rsp_accepted) |->
         ((rsp_effect_kind == KIND_MALFORMED || rsp_effect_kind == KIND_UNSUPPORTED) &&
          rsp_zone_levels == 40'd0 && rsp_vibration_frequency == 8'd0 &&
          rsp_weapon_strength == 4'd0),
      "rejected result is not clean")
   `TEPD_ASSERT(a_weapon_order,
      (rsp_valid && rsp_effect_kind == KIND_WEAPON) |->
         (rsp_end_zone > rsp_start_zone && rsp_weapon_strength != 4'd0),
      "weapon zones out of order")

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// Self-checking bench for the trigger-effect payload decoder: a table of directed packets,
// then random packets. It predicts each result (or takes it from the table) and compares it field by field.
// Depends on tepd_pkg and on the trigger_effect_payload_decoder RTL.
`timescale 1ns / 100ps

module tb_top;
   import tepd_pkg::*;

   localparam int RANDOM_REQUESTS = 900;
   localparam int CYCLE_LIMIT     = 300000;
   localparam int DRAIN_LIMIT     = 5000;
   localparam int REPORT_LINES    = 40;

   // One request transfer: type, length and the ten payload bytes.
   typedef struct packed {
      logic [7:0] effect_type;
      logic [7:0] octet_count;
      octets_type payload;
   } effect_request_type;

   // A directed table row; typed rows carry their result, the rest use the predictor.
   typedef struct {
      effect_request_type request;
      bit                 typed;
      result_type         want;
   } stim_row_type;

   localparam result_type MALFORMED_RESULT   = {1'b0, KIND_MALFORMED, 60'd0};
   localparam result_type UNSUPPORTED_RESULT = {1'b0, KIND_UNSUPPORTED, 60'd0};
   localparam result_type IDLE_RESULT        = {1'b1, KIND_NONE, 60'd0};

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_effect_type;
   logic [7:0]  req_octet_count;
   logic [7:0]  req_octet_0, req_octet_1, req_octet_2, req_octet_3, req_octet_4;
   logic [7:0]  req_octet_5, req_octet_6, req_octet_7, req_octet_8, req_octet_9;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_accepted;
   logic [2:0]  rsp_effect_kind;
   logic [39:0] rsp_zone_levels;
   logic [7:0]  rsp_vibration_frequency;
   logic [3:0]  rsp_start_zone;
   logic [3:0]  rsp_end_zone;
   logic [3:0]  rsp_weapon_strength;

   result_type   pending_results[$];
   stim_row_type directed_rows[$];
   result_type   oldest;
   int          mismatches   = 0;
   int          requests_sent = 0;
   int          results_seen = 0;
   int          cycle_count  = 0;
   int          stall_left   = 0;
   int          drain_cycles = 0;
   int          kind_count[0:7] = '{default: 0};

   trigger_effect_payload_decoder uut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_effect_type         (req_effect_type),
      .req_octet_count         (req_octet_count),
      .req_octet_0             (req_octet_0),
      .req_octet_1             (req_octet_1),
      .req_octet_2             (req_octet_2),
      .req_octet_3             (req_octet_3),
      .req_octet_4             (req_octet_4),
      .req_octet_5             (req_octet_5),
      .req_octet_6             (req_octet_6),
      .req_octet_7             (req_octet_7),
      .req_octet_8             (req_octet_8),
      .req_octet_9             (req_octet_9),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_accepted            (rsp_accepted),
      .rsp_effect_kind         (rsp_effect_kind),
      .rsp_zone_levels         (rsp_zone_levels),
      .rsp_vibration_frequency (rsp_vibration_frequency),
      .rsp_start_zone          (rsp_start_zone),
      .rsp_end_zone            (rsp_end_zone),
      .rsp_weapon_strength     (rsp_weapon_strength)
   );

   always #5 clock = ~clock;

   // Prints one line per mismatch (up to a cap) and counts every one.
   task automatic report_mismatch(input string what, input int seq,
                                  input logic [63:0] got, input logic [63:0] want);
      if (mismatches < REPORT_LINES) begin
         $display("MISMATCH result %0d %s: got %0h, expected %0h", seq, what, got, want);
      end
      mismatches++;
   endtask

   // Decodes one request into the result the block should deliver.
   function automatic result_type decode_effect(input effect_request_type rq);
      result_type  res;
      logic [15:0] mask;
      logic [31:0] packed_levels;
      logic [2:0]  code;
      logic        vib;
      logic        ok;
      int          first;
      int          last;
      int          count;
      res           = '0;
      mask          = {rq.payload[1], rq.payload[0]};
      packed_levels = {rq.payload[5], rq.payload[4], rq.payload[3], rq.payload[2]};
      first         = 0;
      last          = 0;
      count         = 0;
      if (rq.octet_count != PAYLOAD_LEN) begin
         return MALFORMED_RESULT;
      end
      case (rq.effect_type)
         TYPE_OFF: begin
            return (rq.payload == '0) ? IDLE_RESULT : MALFORMED_RESULT;
         end
         TYPE_FEEDBACK, TYPE_VIBRATION: begin
            vib = (rq.effect_type == TYPE_VIBRATION);
            ok  = rq.payload[6] == 8'd0 && rq.payload[7] == 8'd0 && rq.payload[9] == 8'd0 &&
                  (vib || rq.payload[8] == 8'd0);
            if (mask[15:10] != '0 || packed_levels[31:30] != '0) begin
               ok = 1'b0;
            end
            // A level code on a zone outside the mask spoils the packet.
            for (int i = 0; i < ZONES; i++) begin
               code = packed_levels[3*i +: 3];
               if (!mask[i] && code != 3'd0) begin
                  ok = 1'b0;
               end else if (mask[i]) begin
                  res.zone_levels[4*i +: 4] = {1'b0, code} + 4'd1;
               end
            end
            if (!ok) begin
               return MALFORMED_RESULT;
            end
            // An empty mask, or vibration at zero frequency, is a plain stop.
            if (mask == '0 || (vib && rq.payload[8] == 8'd0)) begin
               return IDLE_RESULT;
            end
            res.accepted            = 1'b1;
            res.effect_kind         = vib ? KIND_VIBRATION : KIND_FEEDBACK;
            res.vibration_frequency = vib ? rq.payload[8] : 8'd0;
            return res;
         end
         TYPE_WEAPON: begin
            if (mask[15:10] != '0 || rq.payload[2] > 8'd7 || rq.payload[9:3] != '0) begin
               return MALFORMED_RESULT;
            end
            for (int i = 0; i < ZONES; i++) begin
               if (mask[i]) begin
                  if (count == 0) begin
                     first = i;
                  end
                  last = i;
                  count++;
               end
            end
            if (count != 2 || first < WEAPON_START_MIN || first > WEAPON_START_MAX ||
                last <= first || last > WEAPON_END_MAX) begin
               return MALFORMED_RESULT;
            end
            res.accepted        = 1'b1;
            res.effect_kind     = KIND_WEAPON;
            res.start_zone      = 4'(first);
            res.end_zone        = 4'(last);
            res.weapon_strength = rq.payload[2][3:0] + 4'd1;
            return res;
         end
         default: begin
            return UNSUPPORTED_RESULT;
         end
      endcase
   endfunction

   // Gap length: mostly none, sometimes short, now and then long.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 65) begin
         return 0;
      end
      if (roll < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(4, 24);
   endfunction

   // Random packet: mostly well-formed feedback, vibration and weapon, the rest noise.
   function automatic effect_request_type random_request();
      effect_request_type rq;
      logic [9:0]      mask;
      logic [29:0]     levels;
      logic [79:0]     flat;
      int              pick;
      int              first;
      int              last;
      int              bit_pos;
      rq.effect_type    = TYPE_FEEDBACK;
      rq.octet_count    = PAYLOAD_LEN;
      rq.payload        = '0;
      pick              = $urandom_range(0, 99);
      if (pick < 40) begin
         rq.effect_type = ($urandom_range(0, 1) != 0) ? TYPE_VIBRATION : TYPE_FEEDBACK;
         mask   = ($urandom_range(0, 7) == 0) ? 10'h3FF : 10'($urandom_range(0, 1023));
         levels = '0;
         for (int i = 0; i < ZONES; i++) begin
            if (mask[i]) begin
               levels[3*i +: 3] = 3'($urandom_range(0, 7));
            end
         end
         rq.payload[0] = mask[7:0];
         rq.payload[1] = {6'd0, mask[9:8]};
         {rq.payload[5], rq.payload[4], rq.payload[3], rq.payload[2]} = {2'b00, levels};
         if (rq.effect_type == TYPE_VIBRATION && $urandom_range(0, 9) != 0) begin
            rq.payload[8] = 8'($urandom_range(0, 255));
         end
      end else if (pick < 65) begin
         rq.effect_type = TYPE_WEAPON;
         if ($urandom_range(0, 4) == 0) begin
            first = $urandom_range(0, 9);
            last  = $urandom_range(0, 9);
         end else begin
            first = $urandom_range(2, 7);
            last  = $urandom_range(first + 1, 8);
         end
         mask          = (10'd1 << first) | (10'd1 << last);
         rq.payload[0] = mask[7:0];
         rq.payload[1] = {6'd0, mask[9:8]};
         rq.payload[2] = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                     : 8'($urandom_range(0, 7));
      end else if (pick < 72) begin
         rq.effect_type = TYPE_OFF;
         if ($urandom_range(0, 1) != 0) begin
            rq.payload[$urandom_range(0, 9)] = 8'($urandom_range(1, 255));
         end
      end else if (pick < 85) begin
         case ($urandom_range(0, 4))
            0:       rq.effect_type = TYPE_OFF;
            1:       rq.effect_type = TYPE_FEEDBACK;
            2:       rq.effect_type = TYPE_VIBRATION;
            3:       rq.effect_type = TYPE_WEAPON;
            default: rq.effect_type = 8'($urandom_range(0, 255));
         endcase
         rq.payload = 80'({$urandom, $urandom, $urandom});
      end else if (pick < 95) begin
         rq = {$urandom, $urandom, $urandom};
      end else begin
         rq.effect_type    = TYPE_WEAPON + 8'($urandom_range(0, 1));
         rq.octet_count    = 8'($urandom_range(8, 12));
         rq.payload[0]     = 8'h04;
         rq.payload[1]     = 8'h01;
      end
      // Spoil a share of the structured packets by one payload bit.
      if (pick < 72 && $urandom_range(0, 6) == 0) begin
         flat          = rq.payload;
         bit_pos       = $urandom_range(0, 79);
         flat[bit_pos] = ~flat[bit_pos];
         rq.payload    = flat;
      end
      return rq;
   endfunction

   task automatic add_row(input logic [7:0] effect_type, input logic [7:0] length,
                          input logic [79:0] bytes, input bit typed, input result_type want);
      stim_row_type row;
      row.request.effect_type    = effect_type;
      row.request.octet_count    = length;
      row.request.payload        = bytes;
      row.typed                  = typed;
      row.want                   = want;
      directed_rows.push_back(row);
   endtask

   task automatic apply_request(input effect_request_type rq);
      req_effect_type    <= rq.effect_type;
      req_octet_count    <= rq.octet_count;
      req_octet_0        <= rq.payload[0];
      req_octet_1        <= rq.payload[1];
      req_octet_2        <= rq.payload[2];
      req_octet_3        <= rq.payload[3];
      req_octet_4        <= rq.payload[4];
      req_octet_5        <= rq.payload[5];
      req_octet_6        <= rq.payload[6];
      req_octet_7        <= rq.payload[7];
      req_octet_8        <= rq.payload[8];
      req_octet_9        <= rq.payload[9];
   endtask

   // Drops valid for a while and puts noise on the payload, which must be ignored.
   task automatic idle_for(input int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         apply_request({$urandom, $urandom, $urandom});
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Holds the request until the transfer happens, then records its expected result.
   task automatic send_request(input effect_request_type rq, input bit typed,
                               input result_type want);
      apply_request(rq);
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      pending_results.push_back(typed ? want : decode_effect(rq));
      requests_sent++;
   endtask

   // Result side: checks each transfer against the oldest expectation and stalls at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               report_mismatch("arrived with no request outstanding", results_seen, '0, '0);
            end else begin
               oldest = pending_results.pop_front();
               if (rsp_accepted !== oldest.accepted)
                  report_mismatch("accepted", results_seen, 64'(rsp_accepted),
                                  64'(oldest.accepted));
               if (rsp_effect_kind !== oldest.effect_kind)
                  report_mismatch("effect_kind", results_seen, 64'(rsp_effect_kind),
                                  64'(oldest.effect_kind));
               if (rsp_zone_levels !== oldest.zone_levels)
                  report_mismatch("zone_levels", results_seen, 64'(rsp_zone_levels),
                                  64'(oldest.zone_levels));
               if (rsp_vibration_frequency !== oldest.vibration_frequency)
                  report_mismatch("vibration_frequency", results_seen,
                                  64'(rsp_vibration_frequency),
                                  64'(oldest.vibration_frequency));
               if (rsp_start_zone !== oldest.start_zone)
                  report_mismatch("start_zone", results_seen, 64'(rsp_start_zone),
                                  64'(oldest.start_zone));
               if (rsp_end_zone !== oldest.end_zone)
                  report_mismatch("end_zone", results_seen, 64'(rsp_end_zone),
                                  64'(oldest.end_zone));
               if (rsp_weapon_strength !== oldest.weapon_strength)
                  report_mismatch("weapon_strength", results_seen, 64'(rsp_weapon_strength),
                                  64'(oldest.weapon_strength));
            end
            kind_count[rsp_effect_kind]++;
            results_seen++;
         end
         // One window in three of the cycle counter starts no new stall.
         if (stall_left > 0) begin
            rsp_stall  <= 1'b1;
            stall_left <= stall_left - 1;
         end else begin
            rsp_stall  <= 1'b0;
            stall_left <= ((cycle_count / 400) % 3 == 1) ? 0 : pick_gap();
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Request side: reset, the directed table, then the random packets.
   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      apply_request('0);
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Payload bytes are listed from byte 9 down to byte 0.
      add_row(TYPE_OFF, PAYLOAD_LEN, 80'h00_00_00_00_00_00_00_00_00_00, 1'b1, IDLE_RESULT);
      add_row(TYPE_OFF, PAYLOAD_LEN, 80'hFF_00_00_00_00_00_00_00_00_00, 1'b1,
              MALFORMED_RESULT);
      add_row(TYPE_OFF, 8'd0, 80'h00_00_00_00_00_00_00_00_00_00, 1'b1, MALFORMED_RESULT);
      add_row(TYPE_FEEDBACK, 8'd255, 80'h00_00_00_00_00_00_00_00_00_00, 1'b1,
              MALFORMED_RESULT);
      add_row(TYPE_FEEDBACK, 8'd9, 80'h00_00_00_00_00_00_00_00_03_FF, 1'b1,
              MALFORMED_RESULT);
      add_row(TYPE_WEAPON, 8'd11, 80'h00_00_00_00_00_00_00_07_01_04, 1'b1,
              MALFORMED_RESULT);
      add_row(8'h00, PAYLOAD_LEN, 80'h00_00_00_00_00_00_00_00_00_00, 1'b1,
              UNSUPPORTED_RESULT);
      add_row(8'hFF, PAYLOAD_LEN, 80'hFF_FF_FF_FF_FF_FF_FF_FF_FF_FF, 1'b1,
              UNSUPPORTED_RESULT);
      // Full mask at the top level in every zone.
      add_row(TYPE_FEEDBACK, PAYLOAD_LEN, 80'h00_00_00_00_3F_FF_FF_FF_03_FF, 1'b0, '0);
      add_row(TYPE_VIBRATION, PAYLOAD_LEN, 80'h00_FF_00_00_3F_FF_FF_FF_03_FF, 1'b0, '0);
      // Empty mask, and vibration at zero frequency.
      add_row(TYPE_FEEDBACK, PAYLOAD_LEN, 80'h00_00_00_00_00_00_00_00_00_00, 1'b1,
              IDLE_RESULT);
      add_row(TYPE_VIBRATION, PAYLOAD_LEN, 80'h00_00_00_00_00_00_00_05_00_01, 1'b1,
              IDLE_RESULT);
      // Mask beyond ten zones, packed word beyond 30 bits, stray level, reserved bytes.
      add_row(TYPE_FEEDBACK, PAYLOAD_LEN, 80'h00_00_00_00_00_00_00_00_04_00, 1'b1,
              MALFORMED_RESULT);
      add_row(TYPE_FEEDBACK, PAYLOAD_LEN, 80'h00_00_00_00_40_00_00_00_03_FF, 1'b1,
              MALFORMED_RESULT);
      add_row(TYPE_FEEDBACK, PAYLOAD_LEN, 80'h00_00_00_00_00_00_00_08_00_01, 1'b1,
              MALFORMED_RESULT);
      add_row(TYPE_FEEDBACK, PAYLOAD_LEN, 80'h00_01_00_00_00_00_00_00_00_01, 1'b1,
              MALFORMED_RESULT);
      add_row(TYPE_VIBRATION, PAYLOAD_LEN, 80'h00_80_00_01_00_00_00_00_00_01, 1'b1,
              MALFORMED_RESULT);
      // Weapon at the edges of its zone range and strength.
      add_row(TYPE_WEAPON, PAYLOAD_LEN, 80'h00_00_00_00_00_00_00_07_01_04, 1'b1,
              {1'b1, KIND_WEAPON, 48'd0, 4'd2, 4'd8, 4'd8});
      add_row(TYPE_WEAPON, PAYLOAD_LEN, 80'h00_00_00_00_00_00_00_00_01_80, 1'b1,
              {1'b1, KIND_WEAPON, 48'd0, 4'd7, 4'd8, 4'd1});
      add_row(TYPE_WEAPON, PAYLOAD_LEN, 80'h00_00_00_00_00_00_00_03_00_06, 1'b1,
              MALFORMED_RESULT);
      add_row(TYPE_WEAPON, PAYLOAD_LEN, 80'h00_00_00_00_00_00_00_03_02_04, 1'b1,
              MALFORMED_RESULT);
      add_row(TYPE_WEAPON, PAYLOAD_LEN, 80'h00_00_00_00_00_00_00_03_01_14, 1'b1,
              MALFORMED_RESULT);
      add_row(TYPE_WEAPON, PAYLOAD_LEN, 80'h00_00_00_00_00_00_00_08_00_0C, 1'b1,
              MALFORMED_RESULT);
      add_row(TYPE_WEAPON, PAYLOAD_LEN, 80'h01_00_00_00_00_00_00_03_00_0C, 1'b1,
              MALFORMED_RESULT);
      // Alternate zones with mixed levels.
      add_row(TYPE_FEEDBACK, PAYLOAD_LEN, 80'h00_00_00_00_02_1C_50_C1_01_55, 1'b0, '0);
      add_row(TYPE_VIBRATION, PAYLOAD_LEN, 80'h00_01_00_00_02_1C_50_C1_01_55, 1'b0, '0);

      foreach (directed_rows[i]) begin
         idle_for(pick_gap());
         send_request(directed_rows[i].request, directed_rows[i].typed,
                      directed_rows[i].want);
      end

      // Every third block of 100 packets goes back to back.
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         idle_for(((n / 100) % 3 == 2) ? 0 : pick_gap());
         send_request(random_request(), 1'b0, '0);
      end
      idle_for(1);

      // Wait for the outstanding results, then keep watching for anything stray.
      while (pending_results.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (8) @(posedge clock);
      if (pending_results.size() != 0) begin
         report_mismatch("never delivered", results_seen, 64'(pending_results.size()), '0);
      end

      $display("Sent %0d packets (%0d from the directed table), checked %0d results.",
               requests_sent, directed_rows.size(), results_seen);
      $display("Kinds seen: none %0d, feedback %0d, vibration %0d, weapon %0d, %s %0d, %s %0d.",
               kind_count[KIND_NONE], kind_count[KIND_FEEDBACK], kind_count[KIND_VIBRATION],
               kind_count[KIND_WEAPON], "malformed", kind_count[KIND_MALFORMED],
               "unsupported", kind_count[KIND_UNSUPPORTED]);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
